>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the key press classifier.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/kpc_pkg.sv
// Package for the key press classifier: sizes, phase codes and CSR indexes.
// No dependencies; imported by key_press_classifier_top.
`timescale 1ns / 1ps

package kpc_pkg;

   localparam int NUM_KEYS  = 4;
   localparam int TIME_BITS = 16;

   localparam int ACT_W    = 4;
   localparam int FILTER_W = 8;
   localparam int SHORT_W  = 12;
   localparam int LONG_W   = 15;
   localparam int CSR_W    = 15;
   localparam int CSR_IDX_W = 2;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [2:0]           phase_type;

   // Key phases
   localparam phase_type PH_IDLE  = 3'd0;
   localparam phase_type PH_TRIG  = 3'd1;
   localparam phase_type PH_PFILT = 3'd2;
   localparam phase_type PH_SHORT = 3'd3;
   localparam phase_type PH_SREL  = 3'd4;
   localparam phase_type PH_LONG  = 3'd5;
   localparam phase_type PH_LREL  = 3'd6;
   localparam phase_type PH_RFILT = 3'd7;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TICKS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS    = 2'd3;

   localparam logic [ACT_W-1:0]    ACTIVE_RESET = 4'd0;
   localparam logic [FILTER_W-1:0] FILTER_RESET = 8'd2;
   localparam logic [SHORT_W-1:0]  SHORT_RESET  = 12'd50;
   localparam logic [LONG_W-1:0]   LONG_RESET   = 15'd2000;

endpackage

>>> rtl/core/key_press_classifier_top.sv
// Key press classifier top level: debounce and short/long press detection.
// Depends on kpc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
//
// Usage:
//   Each req_ word is one scan tick: req_trigger_mask flags keys whose pin
//   edge was seen, req_pin_levels carries the sampled pin levels. Each tick
//   yields exactly one rsp_ word with per-key short and long event bits.
//   Both channels use valid/ready; a word moves when valid and ready are high.
//   A tick passes through the input register and then the result register before it is shown on rsp_.
//   Throughput: one tick per clock while rsp_ready stays high; the input register,
//   the per-key phase logic and the result register form a two-stage pipeline.
//   When rsp_ready is low, the result holds and the input register fills;
//   req_ready drops once both are occupied, and resumes as soon as the
//   result word is taken.
//   Configuration: csr_we writes csr_wdata into register csr_index
//   (0 active levels, 1 filter ticks, 2 short ticks, 3 long ticks) at once;
//   write only while no tick is in flight.
//   Reset (synchronous, active high) clears the tick counter, sets every
//   key idle, empties both stages and restores the register defaults.
//
module key_press_classifier_top
   import kpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [NUM_KEYS-1:0]  req_trigger_mask,
   input  logic [NUM_KEYS-1:0]  req_pin_levels,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [NUM_KEYS-1:0]  rsp_short_events,
   output logic [NUM_KEYS-1:0]  rsp_long_events,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

`include "assert_macros.svh"

   // Configuration registers
   logic [ACT_W-1:0]    active_ff;
   logic [FILTER_W-1:0] filter_ff;
   logic [SHORT_W-1:0]  short_ff;
   logic [LONG_W-1:0]   long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         filter_ff <= FILTER_RESET;
         short_ff  <= SHORT_RESET;
         long_ff   <= LONG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE_LEVELS: active_ff <= csr_wdata[ACT_W-1:0];
            CSR_FILTER_TICKS:  filter_ff <= csr_wdata[FILTER_W-1:0];
            CSR_SHORT_TICKS:   short_ff  <= csr_wdata[SHORT_W-1:0];
            CSR_LONG_TICKS:    long_ff   <= csr_wdata[LONG_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   logic                in_valid_ff;
   logic [NUM_KEYS-1:0] trig_ff;
   logic [NUM_KEYS-1:0] pins_ff;
   logic                fire;
   logic                req_take;

   // Result register
   logic                rsp_valid_ff;
   logic [NUM_KEYS-1:0] short_ev_ff;
   logic [NUM_KEYS-1:0] long_ev_ff;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         trig_ff <= req_trigger_mask;
         pins_ff <= req_pin_levels;
      end
   end

   // Tick counter advances once per processed tick
   time_type tick_ff;
   time_type tick_in;

   assign tick_in = tick_ff + time_type'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (fire) begin
         tick_ff <= tick_in;
      end
   end

   time_type filter_thr;
   time_type short_thr;
   time_type long_thr;

   assign filter_thr = time_type'(filter_ff);
   assign short_thr  = time_type'(short_ff);
   assign long_thr   = time_type'(long_ff);

   phase_type           phase_ff [NUM_KEYS];
   phase_type           phase_in [NUM_KEYS];
   time_type            press_ff [NUM_KEYS];
   time_type            press_in [NUM_KEYS];
   time_type            rel_ff   [NUM_KEYS];
   time_type            rel_in   [NUM_KEYS];
   logic [NUM_KEYS-1:0] short_ev_in;
   logic [NUM_KEYS-1:0] long_ev_in;

   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
      logic      pressed;
      phase_type ph;
      time_type  d_press;
      time_type  d_rel;
      logic      press_filt_ok;
      logic      short_ok;
      logic      long_ok;
      logic      rel_filt_ok;

      assign pressed       = !(pins_ff[k] ^ active_ff[k]);
      assign d_press       = tick_in - press_ff[k];
      assign d_rel         = tick_in - rel_ff[k];
      assign press_filt_ok = d_press >= filter_thr;
      assign short_ok      = d_press >= short_thr;
      assign long_ok       = d_press >= long_thr;
      assign rel_filt_ok   = d_rel >= filter_thr;

      // Edge flag wakes an idle key only
      assign ph = (trig_ff[k] && phase_ff[k] == PH_IDLE) ? PH_TRIG : phase_ff[k];

      always_comb begin
         phase_in[k]    = ph;
         press_in[k]    = press_ff[k];
         rel_in[k]      = rel_ff[k];
         short_ev_in[k] = 1'b0;
         long_ev_in[k]  = 1'b0;
         unique case (ph)
            PH_TRIG: begin
               if (pressed) begin
                  press_in[k] = tick_in;
                  phase_in[k] = PH_PFILT;
               end
            end
            PH_PFILT: begin
               if (!pressed) begin
                  phase_in[k] = PH_IDLE;
               end else if (press_filt_ok) begin
                  press_in[k] = tick_in;
                  phase_in[k] = PH_SHORT;
               end
            end
            PH_SHORT: begin
               if (!pressed) begin
                  phase_in[k] = PH_SREL;
                  rel_in[k]   = tick_in;
               end else if (short_ok) begin
                  phase_in[k] = PH_LONG;
               end
            end
            PH_SREL: begin
               if (pressed) begin
                  phase_in[k] = PH_SHORT;
               end else if (rel_filt_ok) begin
                  phase_in[k]    = PH_IDLE;
                  short_ev_in[k] = short_ok;
               end
            end
            PH_LONG: begin
               if (pressed) begin
                  if (long_ok) begin
                     phase_in[k]   = PH_LREL;
                     long_ev_in[k] = 1'b1;
                  end
               end else begin
                  phase_in[k] = long_ok ? PH_LREL : PH_SREL;
                  rel_in[k]   = tick_in;
               end
            end
            PH_LREL: begin
               // Still held: push the release window one tick ahead
               if (pressed) begin
                  rel_in[k] = tick_in + time_type'(1);
               end else if (rel_filt_ok) begin
                  phase_in[k] = PH_IDLE;
               end
            end
            default: ;
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            phase_ff[k] <= PH_IDLE;
            press_ff[k] <= '0;
            rel_ff[k]   <= '0;
         end else if (fire) begin
            phase_ff[k] <= phase_in[k];
            press_ff[k] <= press_in[k];
            rel_ff[k]   <= rel_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         short_ev_ff <= short_ev_in;
         long_ev_ff  <= long_ev_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_short_events = short_ev_ff;
   assign rsp_long_events  = long_ev_ff;

   // Checks
   `ASSERT_IMPLIES(a_events_exclusive, clock, reset, rsp_valid_ff, (short_ev_ff & long_ev_ff) == '0)
   `ASSERT_NEXT(a_tick_advances, clock, reset, fire, (tick_ff - $past(tick_ff)) == time_type'(1))
   `ASSERT_NEXT(a_fire_gives_word, clock, reset, fire, rsp_valid_ff)
   `ASSERT_NEXT(a_stall_holds_input, clock, reset, in_valid_ff && !fire, in_valid_ff && $stable(trig_ff))

endmodule
